// ===== sv/ccso_pkg.sv =====
// Shared types, constants and the OCV correction table of the coulomb counter.
`timescale 1ns / 1ps
package ccso_pkg;

  // Scale factor of the per-mille value.
  localparam int unsigned PERMILLE_SCALE = 1000;

  // Reciprocals for the divisions by constants: x/1000 is (x*COST_RECIP) >> COST_SHIFT
  // for x below 2^31, and x/5 is (x*FIFTH_RECIP) >> FIFTH_SHIFT for any 32-bit x.
  localparam logic [31:0] COST_RECIP  = 32'd2199023256;
  localparam int          COST_SHIFT  = 41;
  localparam logic [31:0] FIFTH_RECIP = 32'hCCCC_CCCD;
  localparam int          FIFTH_SHIFT = 34;

  // OCV voltage ladder in millivolts.
  localparam logic [15:0] MV_3400 = 16'd3400;
  localparam logic [15:0] MV_3300 = 16'd3300;
  localparam logic [15:0] MV_3200 = 16'd3200;
  localparam logic [15:0] MV_3100 = 16'd3100;
  localparam logic [15:0] MV_3000 = 16'd3000;
  localparam logic [15:0] MV_2900 = 16'd2900;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int CUR_W   = 18;
  localparam int MS_W    = 14;
  localparam int MV_W    = 16;
  localparam int CHG_W   = 32;
  localparam int ACC_W   = 40;
  localparam int SOC_W   = 10;
  localparam int THR_W   = 16;
  localparam int IN_DW   = 80;
  localparam int OUT_DW  = 48;

  // Divider geometry: dividend bits shifted in, step count.
  localparam int DIV_BITS_W = 42;
  localparam int DIV_CNT_W  = 6;

  // Step count of the per-mille division.
  localparam logic [DIV_CNT_W-1:0] STEPS_PERMILLE = 6'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_OCV  = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  // Voltage band of the lowest cell, from the top of the ladder down.
  typedef enum logic [2:0] {
    BAND_GE3400 = 3'd0,
    BAND_GE3300 = 3'd1,
    BAND_GE3200 = 3'd2,
    BAND_GE3100 = 3'd3,
    BAND_GE3000 = 3'd4,
    BAND_GE2900 = 3'd5,
    BAND_LOW    = 3'd6
  } band_e;

  // One classified item as it waits in the queue.
  typedef struct packed {
    cmd_e             cmd;
    band_e            band;
    logic [CHG_W-1:0] value;   // signed mA*ms product for a tick, charge for a load
  } q_item_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                  start;
    logic [CHG_W-1:0]      init_rem;
    logic [DIV_BITS_W-1:0] bits;
    logic [DIV_CNT_W-1:0]  steps;
    logic [CHG_W-1:0]      divisor;
  } div_req_t;

  // Answer of the shared divider.
  typedef struct packed {
    logic             done;
    logic [CHG_W-1:0] quot;
  } div_rsp_t;

  // Result of the OCV table for one band and SOC.
  typedef struct packed {
    logic             hit;
    logic [SOC_W-1:0] forced;
    logic [4:0]       div;
    logic [3:0]       mul;
  } ocv_rule_t;

  // OCV band table: forced SOC and the capacity fraction mul/div for it.
  function automatic ocv_rule_t ocv_rule(band_e band, logic [SOC_W-1:0] soc);
    ocv_rule_t r;
    r = '{hit: 1'b0, forced: '0, div: 5'd1, mul: 4'd1};
    case (band)
      BAND_GE3400: begin
        if (soc < 10'd800) r = '{1'b1, 10'd800, 5'd5, 4'd4};
      end
      BAND_GE3300: begin
        if (soc < 10'd500) r = '{1'b1, 10'd500, 5'd2, 4'd1};
      end
      BAND_GE3200: begin
        if (soc < 10'd200) r = '{1'b1, 10'd200, 5'd5, 4'd1};
        else if (soc > 10'd900) r = '{1'b1, 10'd900, 5'd10, 4'd9};
      end
      BAND_GE3100: begin
        if (soc < 10'd50) r = '{1'b1, 10'd50, 5'd20, 4'd1};
        else if (soc > 10'd600) r = '{1'b1, 10'd600, 5'd10, 4'd6};
      end
      BAND_GE3000: begin
        if (soc > 10'd350) r = '{1'b1, 10'd350, 5'd20, 4'd7};
      end
      BAND_GE2900: begin
        if (soc > 10'd200) r = '{1'b1, 10'd200, 5'd5, 4'd1};
      end
      BAND_LOW: begin
        if (soc > 10'd100) r = '{1'b1, 10'd100, 5'd10, 4'd1};
      end
      default: r = '{hit: 1'b0, forced: '0, div: 5'd1, mul: 4'd1};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ccso_front.sv =====
// Front end: classifies an incoming item, forms the charge product and the voltage band.
`timescale 1ns / 1ps
module ccso_front (
  input  logic [ccso_pkg::CMD_W-1:0] cmd_i,
  input  logic [ccso_pkg::IN_DW-1:0] data_i,
  output ccso_pkg::q_item_t          item_o
);
  import ccso_pkg::*;

  logic signed [CUR_W-1:0]   cur;
  logic        [MS_W-1:0]    ms;
  logic        [MV_W-1:0]    mv;
  logic        [CHG_W-1:0]   load_value;
  logic signed [CUR_W+MS_W:0] prod;
  band_e                     band;

  // Unpack the data word, lowest field first.
  assign cur        = signed'(data_i[CUR_W-1:0]);
  assign ms         = data_i[CUR_W+MS_W-1:CUR_W];
  assign mv         = data_i[CUR_W+MS_W+MV_W-1:CUR_W+MS_W];
  assign load_value = data_i[CUR_W+MS_W+MV_W+CHG_W-1:CUR_W+MS_W+MV_W];

  // Charge moved by a tick in mA*ms; the magnitude stays below 2^31.
  assign prod = cur * signed'({1'b0, ms});

  // Place the lowest cell voltage on the OCV ladder.
  always_comb begin
    if (mv >= MV_3400)      band = BAND_GE3400;
    else if (mv >= MV_3300) band = BAND_GE3300;
    else if (mv >= MV_3200) band = BAND_GE3200;
    else if (mv >= MV_3100) band = BAND_GE3100;
    else if (mv >= MV_3000) band = BAND_GE3000;
    else if (mv >= MV_2900) band = BAND_GE2900;
    else                    band = BAND_LOW;
  end

  // Build the queue entry for the command.
  always_comb begin
    item_o.cmd  = cmd_e'(cmd_i);
    item_o.band = band;
    case (cmd_e'(cmd_i))
      CMD_TICK: item_o.value = prod[CHG_W-1:0];
      CMD_LOAD: item_o.value = load_value;
      default:  item_o.value = '0;
    endcase
  end

endmodule

// ===== sv/ccso_queue.sv =====
// Two-entry queue of classified items between the front end and the back end.
`timescale 1ns / 1ps
module ccso_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ccso_pkg::q_item_t push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ccso_pkg::q_item_t head_o
);
  import ccso_pkg::*;

  q_item_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q;
    if (push_i && !pop_i)      count_d = count_q + 2'd1;
    else if (!push_i && pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/ccso_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ccso_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccso_pkg::div_req_t req_i,
  output ccso_pkg::div_rsp_t rsp_o
);
  import ccso_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [CHG_W-1:0]      rem_q;
  logic [DIV_BITS_W-1:0] bits_q;
  logic [CHG_W-1:0]      quot_q;
  logic [CHG_W-1:0]      div_q;
  logic [CHG_W:0]        trial;
  logic                  qbit;
  logic [CHG_W-1:0]      rem_next;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial    = {rem_q, bits_q[DIV_BITS_W-1]} - {1'b0, div_q};
  assign qbit     = ~trial[CHG_W];
  assign rem_next = qbit ? trial[CHG_W-1:0] : {rem_q[CHG_W-2:0], bits_q[DIV_BITS_W-1]};

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder, dividend bits and quotient.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.init_rem;
      bits_q <= req_i.bits;
      quot_q <= '0;
      div_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= rem_next;
      bits_q <= {bits_q[DIV_BITS_W-2:0], 1'b0};
      quot_q <= {quot_q[CHG_W-2:0], qbit};
    end
  end

endmodule

// ===== sv/ccso_back.sv =====
// Back end: executes queued items on the charge state and holds the result register.
`timescale 1ns / 1ps
module ccso_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ccso_pkg::CHG_W-1:0] full_cap_i,
  input  logic [ccso_pkg::THR_W-1:0] flush_thr_i,
  input  logic                       q_valid_i,
  input  ccso_pkg::q_item_t          q_head_i,
  output logic                       q_pop_o,
  output ccso_pkg::div_req_t         div_req_o,
  input  ccso_pkg::div_rsp_t         div_rsp_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ccso_pkg::SOC_W-1:0] out_soc_o,
  output logic                       out_flag_o,
  output logic [ccso_pkg::CHG_W-1:0] out_rem_o
);
  import ccso_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FLUSH = 7'b0000010,
    ST_COST  = 7'b0000100,
    ST_CAP   = 7'b0001000,
    ST_PERM  = 7'b0010000,
    ST_PERMW = 7'b0100000,
    ST_OCVW  = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [CHG_W-1:0]        rem_q, rem_d;
  logic [SOC_W-1:0]        soc_q, soc_d;
  ocv_rule_t               ocv_q, ocv_d;
  logic                    out_valid_q, out_valid_d;
  logic [SOC_W-1:0]        out_soc_q, out_soc_d;
  logic                    out_flag_q, out_flag_d;
  logic [CHG_W-1:0]        out_rem_q, out_rem_d;
  logic [2*CHG_W-1:0]      recip_q, recip_d;

  logic                    start;
  ocv_rule_t               rule;
  logic [ACC_W-1:0]        mag;
  logic                    flush;
  logic [CHG_W-1:0]        mul_a;
  logic [CHG_W-1:0]        mul_b;
  logic [CHG_W-1:0]        cost;
  logic [CHG_W-1:0]        fifth;
  logic [CHG_W-1:0]        ocv_base;
  logic [CHG_W:0]          charge_sum;
  logic [DIV_BITS_W-1:0]   scaled;
  logic [CHG_W+3:0]        ocv_rem;

  assign start = q_valid_i && !out_valid_q && (state_q == ST_IDLE);
  assign q_pop_o = start;
  assign rule  = ocv_rule(q_head_i.band, soc_q);

  // Accumulator magnitude and the flush test against the threshold.
  assign mag   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign flush = mag > {{(ACC_W-THR_W){1'b0}}, flush_thr_i};

  // One reciprocal multiplier: the accumulator magnitude (below 2^31) while the
  // flush is tested, otherwise the capacity. The product is registered.
  assign mul_a   = (state_q == ST_FLUSH) ? {1'b0, mag[30:0]} : full_cap_i;
  assign mul_b   = (state_q == ST_FLUSH) ? COST_RECIP : FIFTH_RECIP;
  assign recip_d = {{CHG_W{1'b0}}, mul_a} * {{CHG_W{1'b0}}, mul_b};
  assign cost    = CHG_W'(recip_q[2*CHG_W-1:COST_SHIFT]);
  assign fifth   = CHG_W'(recip_q[2*CHG_W-1:FIFTH_SHIFT]);

  // Capacity fraction of the OCV rule: halves by shift, tenths and twentieths from a fifth.
  always_comb begin
    case (ocv_q.div)
      5'd2:    ocv_base = {1'b0, full_cap_i[CHG_W-1:1]};
      5'd10:   ocv_base = {1'b0, fifth[CHG_W-1:1]};
      5'd20:   ocv_base = {2'b0, fifth[CHG_W-1:2]};
      default: ocv_base = fifth;
    endcase
  end

  assign charge_sum = {1'b0, rem_q} + {1'b0, cost};
  assign scaled     = {{(DIV_BITS_W-CHG_W){1'b0}}, rem_q} * DIV_BITS_W'(PERMILLE_SCALE);
  assign ocv_rem    = {4'b0, ocv_base} * {{CHG_W{1'b0}}, ocv_q.mul};

  assign out_valid_o = out_valid_q;
  assign out_soc_o   = out_soc_q;
  assign out_flag_o  = out_flag_q;
  assign out_rem_o   = out_rem_q;

  // Sequencer over the item's steps, divider requests and result capture.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    soc_d       = soc_q;
    ocv_d       = ocv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_soc_d   = out_soc_q;
    out_flag_d  = out_flag_q;
    out_rem_d   = out_rem_q;
    div_req_o   = '{start: 1'b0, init_rem: '0, bits: '0, steps: STEPS_PERMILLE,
                    divisor: CHG_W'(1)};

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (q_head_i.cmd)
            CMD_TICK: begin
              if (full_cap_i == '0) begin
                out_valid_d = 1'b1;
                out_soc_d   = '0;
                out_flag_d  = 1'b0;
                out_rem_d   = rem_q;
              end else begin
                acc_d   = acc_q + ACC_W'(signed'(q_head_i.value));
                state_d = ST_FLUSH;
              end
            end
            CMD_OCV: begin
              if (rule.hit) begin
                ocv_d   = rule;
                state_d = ST_OCVW;
              end else begin
                out_valid_d = 1'b1;
                out_soc_d   = '0;
                out_flag_d  = 1'b0;
                out_rem_d   = rem_q;
              end
            end
            CMD_LOAD: begin
              rem_d   = (q_head_i.value > full_cap_i) ? full_cap_i : q_head_i.value;
              state_d = ST_PERM;
            end
            default: begin
              out_valid_d = 1'b1;
              out_soc_d   = soc_q;
              out_flag_d  = 1'b0;
              out_rem_d   = rem_q;
            end
          endcase
        end
      end

      // Apply the accumulator once it leaves the threshold band.
      ST_FLUSH: begin
        if (flush) begin
          state_d = ST_COST;
        end else begin
          state_d = ST_CAP;
        end
      end

      // Cost in mA*s is ready: discharge floors at zero, charge caps at full.
      ST_COST: begin
        if (acc_q[ACC_W-1]) begin
          rem_d = (rem_q < cost) ? '0 : rem_q - cost;
        end else begin
          rem_d = (charge_sum > {1'b0, full_cap_i}) ? full_cap_i
                                                    : charge_sum[CHG_W-1:0];
        end
        acc_d   = '0;
        state_d = ST_CAP;
      end

      ST_CAP: begin
        if (rem_q > full_cap_i) rem_d = full_cap_i;
        state_d = ST_PERM;
      end

      // Per mille: rem*1000/F, quotient known to be below 1024.
      ST_PERM: begin
        if (full_cap_i == '0) begin
          soc_d       = '0;
          out_valid_d = 1'b1;
          out_soc_d   = '0;
          out_flag_d  = 1'b0;
          out_rem_d   = rem_q;
          state_d     = ST_IDLE;
        end else begin
          div_req_o = '{start: 1'b1,
                        init_rem: scaled[DIV_BITS_W-1:DIV_BITS_W-CHG_W],
                        bits: {scaled[DIV_BITS_W-CHG_W-1:0], {CHG_W{1'b0}}},
                        steps: STEPS_PERMILLE, divisor: full_cap_i};
          state_d   = ST_PERMW;
        end
      end

      ST_PERMW: begin
        if (div_rsp_i.done) begin
          soc_d       = div_rsp_i.quot[SOC_W-1:0];
          out_valid_d = 1'b1;
          out_soc_d   = div_rsp_i.quot[SOC_W-1:0];
          out_flag_d  = 1'b0;
          out_rem_d   = rem_q;
          state_d     = ST_IDLE;
        end
      end

      // Forced remaining charge is the band edge fraction of capacity.
      ST_OCVW: begin
        rem_d       = ocv_rem[CHG_W-1:0];
        out_valid_d = 1'b1;
        out_soc_d   = ocv_q.forced;
        out_flag_d  = 1'b1;
        out_rem_d   = ocv_rem[CHG_W-1:0];
        state_d     = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      rem_q       <= '0;
      soc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      soc_q       <= soc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, OCV rule hold and the multiplier product need no reset.
  always_ff @(posedge clk_i) begin
    ocv_q      <= ocv_d;
    out_soc_q  <= out_soc_d;
    out_flag_q <= out_flag_d;
    out_rem_q  <= out_rem_d;
    recip_q    <= recip_d;
  end

endmodule

// ===== sv/coulomb_counter_soc_ocv.sv =====
// Top level of the coulomb counter with OCV correction.
`timescale 1ns / 1ps
// Coulomb counter with open-circuit-voltage correction. Items enter on the
// s_axis side (tuser selects tick, OCV check or load) and each gives exactly one
// result on the m_axis side. A two-entry queue decouples input acceptance from
// execution; the back end starts an item only once the previous result has been
// taken, so items run one at a time. A tick runs the flush test and, on a flush, a
// registered reciprocal multiply for the mA*s cost, then the capacity clamp and
// 10 steps of the shared divider for the per-mille value, whose answer is caught
// in a state of its own; a load runs the same division. An OCV check that forces
// the charge waits for a registered reciprocal multiply for a fifth of capacity.
// Other OCV checks, a tick or load at zero capacity and unused commands answer
// without the divider. Registers must be written over APB only while the block
// is idle; the block itself does not enforce this.
module coulomb_counter_soc_ocv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input items
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [17:0] current_ma, [31:18] elapsed_ms, [47:32] cell_min_mv, [79:48] load_value
  input  logic [ccso_pkg::IN_DW-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [ccso_pkg::CMD_W-1:0]  s_axis_tuser,
  // Result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [9:0] soc_permille, [41:10] remaining_out, [47:42] zero
  output logic [ccso_pkg::OUT_DW-1:0] m_axis_tdata,
  // [0] ocv_applied
  output logic                        m_axis_tuser,
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ccso_pkg::*;

  logic [CHG_W-1:0] full_cap_q;
  logic [THR_W-1:0] flush_thr_q;
  logic             cfg_wr;
  q_item_t          front_item;
  q_item_t          q_head;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [SOC_W-1:0] out_soc;
  logic [CHG_W-1:0] out_rem;

  // Configuration registers: full capacity at 0, flush threshold at 4.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {{(32-THR_W){1'b0}}, flush_thr_q} : full_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_cap_q  <= '0;
      flush_thr_q <= THR_W'(1000);
    end else if (cfg_wr) begin
      if (paddr[2]) flush_thr_q <= pwdata[THR_W-1:0];
      else          full_cap_q  <= pwdata;
    end
  end

  assign s_axis_tready = !q_full;

  ccso_front u_front (
    .cmd_i  (s_axis_tuser),
    .data_i (s_axis_tdata),
    .item_o (front_item)
  );

  ccso_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid && s_axis_tready),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  ccso_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ccso_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .full_cap_i  (full_cap_q),
    .flush_thr_i (flush_thr_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_soc_o   (out_soc),
    .out_flag_o  (m_axis_tuser),
    .out_rem_o   (out_rem)
  );

  assign m_axis_tdata = {{(OUT_DW-SOC_W-CHG_W){1'b0}}, out_rem, out_soc};

endmodule
